// ===== hw/rtl/lfps_pkg.sv =====
// Shared types and constants of the lung feedback random generator.
package lfps_pkg;

	localparam int HALF_W        = 64;
	localparam int WORD_W        = 2 * HALF_W;
	localparam int FRAC_W        = 52;
	localparam int FRACTION_BITS = 52;
	localparam int FRAC_KEEP     = (FRACTION_BITS < FRAC_W) ? FRACTION_BITS : FRAC_W;
	localparam int SHIFT_RIGHT   = 12;
	localparam int SWAP_W        = 32;

	localparam logic [FRAC_W-1:0] MASK52    = 52'hF_FFFF_FFFF_FFFF;
	localparam logic [FRAC_W-1:0] FRAC_MASK = MASK52 >> (FRAC_W - FRAC_KEEP);

	localparam logic [7:0] TAP_RESET   = 8'd117;
	localparam logic [4:0] SHIFT_RESET = 5'd19;

	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_GENERATE = 2'd1,
		OP_CERTIFY  = 2'd2
	} op_e;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_WRITE_WORD,
		KIND_WRITE_LUNG,
		KIND_GENERATE,
		KIND_CERTIFY
	} kind_e;

	typedef enum logic [2:0] {
		CFG_TAP_OFFSET    = 3'd0,
		CFG_SHIFT_LEFT    = 3'd1,
		CFG_MASK_FIRST    = 3'd2,
		CFG_MASK_SECOND   = 3'd3,
		CFG_PARITY_FIRST  = 3'd4,
		CFG_PARITY_SECOND = 3'd5,
		CFG_FIX_FIRST     = 3'd6,
		CFG_FIX_SECOND    = 3'd7
	} cfg_idx_e;

	typedef struct packed {
		kind_e             kind;
		logic [7:0]        word_index;
		logic [HALF_W-1:0] word_first;
		logic [HALF_W-1:0] word_second;
		logic              skip_fix;
	} item_t;

	typedef struct packed {
		logic [7:0]        tap_offset;
		logic [4:0]        shift_left;
		logic [FRAC_W-1:0] mask_first;
		logic [FRAC_W-1:0] mask_second;
		logic [HALF_W-1:0] parity_first;
		logic [HALF_W-1:0] parity_second;
		logic [HALF_W-1:0] fix_first;
		logic [HALF_W-1:0] fix_second;
	} cfg_t;

	typedef struct packed {
		logic s2_valid;
		logic fwd_valid;
	} back_stat_t;

endpackage

// ===== hw/rtl/lfps_front.sv =====
// Front end: accepts input transactions, classifies them and queues them.
module lfps_front #(
	parameter int WORD_COUNT = 191
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [7:0]                 word_index,
	input  logic [lfps_pkg::HALF_W-1:0] word_first,
	input  logic [lfps_pkg::HALF_W-1:0] word_second,
	input  logic                       skip_fix,
	output logic                       q_valid,
	output lfps_pkg::item_t            q_head,
	input  logic                       q_pop
);
	import lfps_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	item_t             item;
	logic              push;
	logic              idx_in_ring;
	logic              idx_is_lung;

	// Classify the incoming transaction
	always_comb begin
		idx_in_ring      = 32'(word_index) < 32'(WORD_COUNT);
		idx_is_lung      = 32'(word_index) == 32'(WORD_COUNT);
		item.kind        = KIND_NONE;
		item.word_index  = word_index;
		item.word_first  = word_first;
		item.word_second = word_second;
		item.skip_fix    = skip_fix;
		case (op)
			OP_WRITE: begin
				if (idx_in_ring) begin
					item.kind = KIND_WRITE_WORD;
				end else if (idx_is_lung) begin
					item.kind = KIND_WRITE_LUNG;
				end
			end
			OP_GENERATE: item.kind = KIND_GENERATE;
			OP_CERTIFY:  item.kind = KIND_CERTIFY;
			default:     item.kind = KIND_NONE;
		endcase
	end

	assign in_ready = count_q != CNT_W'(DEPTH);
	assign push     = in_valid && in_ready;
	assign q_valid  = count_q != '0;
	assign q_head   = entry_q[rd_ptr_q];

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Hold queued payload
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

endmodule

// ===== hw/rtl/lfps_back.sv =====
// Back end: state ring, lung register, step and certify logic, result register.
module lfps_back #(
	parameter int WORD_COUNT = 191,
	parameter int AW = $clog2(WORD_COUNT)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lfps_pkg::cfg_t             cfg,
	input  logic                       q_valid,
	input  lfps_pkg::item_t            q_head,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lfps_pkg::FRAC_W-1:0] fraction_first,
	output logic [lfps_pkg::FRAC_W-1:0] fraction_second,
	output logic [lfps_pkg::HALF_W-1:0] lung_first,
	output logic [lfps_pkg::HALF_W-1:0] lung_second,
	output logic                       certified,
	output lfps_pkg::back_stat_t       stat,
	output logic [AW-1:0]              rd_pos
);
	import lfps_pkg::*;

	localparam int              TAP_DEPTH = 256;
	localparam logic [AW-1:0]   LAST_POS  = AW'(WORD_COUNT - 1);
	localparam logic [AW:0]     COUNT_EXT = (AW + 1)'(WORD_COUNT);

	logic [WORD_W-1:0] mem [WORD_COUNT];
	logic [AW-1:0]     tap_tbl [TAP_DEPTH];

	logic              s2_valid_q;
	logic [AW-1:0]     rd_pos_q;
	item_t             item_s2;
	logic [AW-1:0]     cur_s2;
	logic [AW-1:0]     tap_s2;
	logic [WORD_W-1:0] cur_word_s2;
	logic [WORD_W-1:0] tap_word_s2;
	logic              fwd_valid_q;
	logic [AW-1:0]     fwd_addr_q;
	logic [WORD_W-1:0] fwd_data_q;
	logic [WORD_W-1:0] lung_q;
	logic              out_valid_q;
	logic [FRAC_W-1:0] frac_first_q;
	logic [FRAC_W-1:0] frac_second_q;
	logic [HALF_W-1:0] lung_first_q;
	logic [HALF_W-1:0] lung_second_q;
	logic              certified_q;

	logic              out_free;
	logic              adv;
	logic              exec;
	logic [AW:0]       tap_sum;
	logic [AW-1:0]     tap_addr;
	logic [WORD_W-1:0] cur_word;
	logic [WORD_W-1:0] tap_word;
	logic [HALF_W-1:0] c0, c1, b0, b1, l0, l1;
	logic [HALF_W-1:0] n0, n1, w0, w1;
	logic [HALF_W-1:0] t0, t1, low0, low1;
	logic              parity;
	logic [WORD_W-1:0] lung_next;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [FRAC_W-1:0] frac_first;
	logic [FRAC_W-1:0] frac_second;
	logic              cert;

	function automatic logic [HALF_W-1:0] swap_halves(input logic [HALF_W-1:0] v);
		return {v[SWAP_W-1:0], v[HALF_W-1:SWAP_W]};
	endfunction

	// Pipeline flow: execute stage moves when the result register is free
	assign out_free = !out_valid_q || out_ready;
	assign adv      = !s2_valid_q || out_free;
	assign exec     = s2_valid_q && out_free;
	assign q_pop    = adv && q_valid;

	// Reduce the tap distance modulo the ring length by table
	for (genvar g = 0; g < TAP_DEPTH; g++) begin : g_tap
		assign tap_tbl[g] = AW'(g % WORD_COUNT);
	end

	always_comb begin
		tap_sum = {1'b0, rd_pos_q} + {1'b0, tap_tbl[cfg.tap_offset]};
		if (tap_sum >= COUNT_EXT) begin
			tap_addr = AW'(tap_sum - COUNT_EXT);
		end else begin
			tap_addr = tap_sum[AW-1:0];
		end
	end

	// Issue: take the queue head and advance the read position on a generate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
			rd_pos_q   <= '0;
		end else if (adv) begin
			s2_valid_q <= q_valid;
			if (q_valid && q_head.kind == KIND_GENERATE) begin
				rd_pos_q <= (rd_pos_q == LAST_POS) ? '0 : rd_pos_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2 <= q_head;
			cur_s2  <= rd_pos_q;
			tap_s2  <= tap_addr;
		end
	end

	// Ring memory: two registered reads, one write
	always_ff @(posedge clk) begin
		if (adv) begin
			cur_word_s2 <= mem[rd_pos_q];
			tap_word_s2 <= mem[tap_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Forward the write made in the same cycle as this stage's reads
	always_comb begin
		cur_word = (fwd_valid_q && fwd_addr_q == cur_s2) ? fwd_data_q : cur_word_s2;
		tap_word = (fwd_valid_q && fwd_addr_q == tap_s2) ? fwd_data_q : tap_word_s2;
	end

	// Step and certify arithmetic
	always_comb begin
		c0   = cur_word[HALF_W-1:0];
		c1   = cur_word[WORD_W-1:HALF_W];
		b0   = tap_word[HALF_W-1:0];
		b1   = tap_word[WORD_W-1:HALF_W];
		l0   = lung_q[HALF_W-1:0];
		l1   = lung_q[WORD_W-1:HALF_W];
		n0   = (c0 << cfg.shift_left) ^ swap_halves(l1) ^ b0;
		n1   = (c1 << cfg.shift_left) ^ swap_halves(l0) ^ b1;
		w0   = (n0 >> SHIFT_RIGHT) ^ (n0 & HALF_W'(cfg.mask_first)) ^ c0;
		w1   = (n1 >> SHIFT_RIGHT) ^ (n1 & HALF_W'(cfg.mask_second)) ^ c1;
		t0   = (item_s2.skip_fix ? l0 : (l0 ^ cfg.fix_first)) & cfg.parity_first;
		t1   = (item_s2.skip_fix ? l1 : (l1 ^ cfg.fix_second)) & cfg.parity_second;
		parity = ^(t0 ^ t1);
		low0 = cfg.parity_first & (~cfg.parity_first + HALF_W'(1));
		low1 = cfg.parity_second & (~cfg.parity_second + HALF_W'(1));
	end

	// Select the effect of the operation in the execute stage
	always_comb begin
		lung_next   = lung_q;
		wr_en       = 1'b0;
		wr_addr     = cur_s2;
		wr_data     = {w1, w0};
		frac_first  = '0;
		frac_second = '0;
		cert        = 1'b0;
		case (item_s2.kind)
			KIND_WRITE_WORD: begin
				wr_en   = exec;
				wr_addr = AW'(item_s2.word_index);
				wr_data = {item_s2.word_second, item_s2.word_first};
			end
			KIND_WRITE_LUNG: begin
				lung_next = {item_s2.word_second, item_s2.word_first};
			end
			KIND_GENERATE: begin
				wr_en       = exec;
				lung_next   = {n1, n0};
				frac_first  = c0[FRAC_W-1:0] & FRAC_MASK;
				frac_second = c1[FRAC_W-1:0] & FRAC_MASK;
			end
			KIND_CERTIFY: begin
				cert = parity;
				if (!parity) begin
					if (low1 != '0) begin
						lung_next = {l1 ^ low1, l0};
					end else begin
						lung_next = {l1, l0 ^ low0};
					end
				end
			end
			default: begin
				lung_next = lung_q;
			end
		endcase
	end

	// Update lung, forwarding record and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lung_q      <= '0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (exec) begin
				lung_q <= lung_next;
			end
			if (adv) begin
				fwd_valid_q <= wr_en;
			end
			if (out_free) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	// Hold forwarding payload and result payload
	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_addr_q <= wr_addr;
			fwd_data_q <= wr_data;
		end
		if (exec) begin
			frac_first_q  <= frac_first;
			frac_second_q <= frac_second;
			lung_first_q  <= l0;
			lung_second_q <= l1;
			certified_q   <= cert;
		end
	end

	assign out_valid       = out_valid_q;
	assign fraction_first  = frac_first_q;
	assign fraction_second = frac_second_q;
	assign lung_first      = lung_first_q;
	assign lung_second     = lung_second_q;
	assign certified       = certified_q;
	assign stat.s2_valid   = s2_valid_q;
	assign stat.fwd_valid  = fwd_valid_q;
	assign rd_pos          = rd_pos_q;

endmodule

// ===== hw/rtl/lung_feedback_prng_step_top.sv =====
// Top level of the lung feedback random generator: configuration, front and back ends.
//
//  channel   direction  handshake             payload
//  input     in         in_valid / in_ready   op, word_index, word_first, word_second, skip_fix
//  result    out        out_valid / out_ready fraction_first, fraction_second, lung_first,
//                                             lung_second, certified
//  config    in         cfg_we                cfg_index, cfg_data
//
// One transaction per cycle while out_ready is high; out_valid follows the execute stage.
// The rate is set by the state ring's two registered read ports and one write port,
// with the write of one step forwarded to the reads of the next.
// Reset clears the lung, read position, queue and pipeline; the ring needs no clearing pass.
// A stalled result holds the execute stage; the two-entry queue keeps accepting until full.
module lung_feedback_prng_step_top #(
	parameter int WORD_COUNT = 191
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [lfps_pkg::HALF_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 op,
	input  logic [7:0]                 word_index,
	input  logic [lfps_pkg::HALF_W-1:0] word_first,
	input  logic [lfps_pkg::HALF_W-1:0] word_second,
	input  logic                       skip_fix,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lfps_pkg::FRAC_W-1:0] fraction_first,
	output logic [lfps_pkg::FRAC_W-1:0] fraction_second,
	output logic [lfps_pkg::HALF_W-1:0] lung_first,
	output logic [lfps_pkg::HALF_W-1:0] lung_second,
	output logic                       certified
);
	import lfps_pkg::*;

	localparam int AW = $clog2(WORD_COUNT);

	cfg_t        cfg_q;
	logic        q_valid;
	item_t       q_head;
	logic        q_pop;
	back_stat_t  stat;
	logic [AW-1:0] rd_pos;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_offset    <= TAP_RESET;
			cfg_q.shift_left    <= SHIFT_RESET;
			cfg_q.mask_first    <= '0;
			cfg_q.mask_second   <= '0;
			cfg_q.parity_first  <= '0;
			cfg_q.parity_second <= '0;
			cfg_q.fix_first     <= '0;
			cfg_q.fix_second    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAP_OFFSET:    cfg_q.tap_offset    <= cfg_data[7:0];
				CFG_SHIFT_LEFT:    cfg_q.shift_left    <= cfg_data[4:0];
				CFG_MASK_FIRST:    cfg_q.mask_first    <= cfg_data[FRAC_W-1:0];
				CFG_MASK_SECOND:   cfg_q.mask_second   <= cfg_data[FRAC_W-1:0];
				CFG_PARITY_FIRST:  cfg_q.parity_first  <= cfg_data;
				CFG_PARITY_SECOND: cfg_q.parity_second <= cfg_data;
				CFG_FIX_FIRST:     cfg_q.fix_first     <= cfg_data;
				CFG_FIX_SECOND:    cfg_q.fix_second    <= cfg_data;
				default:           cfg_q.tap_offset    <= cfg_q.tap_offset;
			endcase
		end
	end

	lfps_front #(
		.WORD_COUNT (WORD_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.word_index  (word_index),
		.word_first  (word_first),
		.word_second (word_second),
		.skip_fix    (skip_fix),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop)
	);

	lfps_back #(
		.WORD_COUNT (WORD_COUNT),
		.AW         (AW)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.q_valid         (q_valid),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.fraction_first  (fraction_first),
		.fraction_second (fraction_second),
		.lung_first      (lung_first),
		.lung_second     (lung_second),
		.certified       (certified),
		.stat            (stat),
		.rd_pos          (rd_pos)
	);

	// Read position stays inside the ring
	a_rd_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pos <= AW'(WORD_COUNT - 1))
		else $error("read position outside the ring");

	// A forwarded write always comes from a transaction that was executing
	a_fwd_origin: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fwd_valid |-> $past(stat.s2_valid))
		else $error("forwarding record without an executed write");

	// A blocked result holds the transaction in the execute stage
	a_exec_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stat.s2_valid && out_valid && !out_ready |=> stat.s2_valid)
		else $error("execute stage dropped a transaction under stall");

endmodule
